@@ sv/parametric_sphere_torus_tessellator_core_defines.svh @@
// assertion macros shared by the tessellator modules
// no dependencies; included inside module bodies
`ifndef PARAMETRIC_SPHERE_TORUS_TESSELLATOR_CORE_DEFINES_SVH
`define PARAMETRIC_SPHERE_TORUS_TESSELLATOR_CORE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define TSTC_ASSERT_NOW(LABEL, CLK, RSTN, ANTE, CONS) \
	LABEL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
		else $error("tessellator check failed");

// consequent must hold in the cycle after the antecedent
`define TSTC_ASSERT_NEXT(LABEL, CLK, RSTN, ANTE, CONS) \
	LABEL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
		else $error("tessellator check failed");

`endif

@@ sv/tstc_pkg.sv @@
// shared types, constants and arithmetic helpers of the tessellator
// no dependencies
package tstc_pkg;

	localparam int MAX_SEGMENTS = 256;
	localparam int ANGLE_STEPS  = 16;
	localparam int FRAC_BITS    = 12;

	localparam int SEG_W     = 9;
	localparam int IDX_W     = 17;
	localparam int POS_W     = 17;
	localparam int NORM_W    = 16;
	localparam int TEX_W     = 16;
	localparam int RAD_W     = 15;
	localparam int TURN_BITS = 24;
	localparam int QUO_W     = TURN_BITS + 1;
	localparam int TEX_FRAC  = 15;
	localparam int TEX_SHIFT = TURN_BITS - TEX_FRAC;
	localparam int DIV_LAT   = TURN_BITS + 1;
	localparam int CORDIC_W  = 32;
	localparam int ZW        = 26;
	localparam int WIDE_W    = 48;
	localparam int NORM_FRAC = 14;
	localparam int PROD_FRAC = 2 * NORM_FRAC;
	localparam int RAD_FRAC  = 12;
	localparam int TOR_FRAC  = PROD_FRAC + RAD_FRAC;
	localparam int NORM_LIM  = 16384;
	localparam int POS_MAX   = 65535;
	localparam int POS_MIN   = -65536;

	localparam int QUEUE_DEPTH = 4;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	localparam logic signed [CORDIC_W-1:0] CORDIC_START = 32'sd163008219;
	localparam logic signed [ZW-1:0]       EIGHTH       = 26'sd2097152;

	localparam logic [21:0] ATAN_TAB [24] = '{
		22'd2097152, 22'd1238021, 22'd654136, 22'd332050, 22'd166669, 22'd83416,
		22'd41718, 22'd20860, 22'd10430, 22'd5215, 22'd2608, 22'd1304,
		22'd652, 22'd326, 22'd163, 22'd81, 22'd41, 22'd20,
		22'd10, 22'd5, 22'd3, 22'd1, 22'd1, 22'd0
	};

	typedef enum logic {CMD_VERTEX = 1'b0, CMD_CELL = 1'b1} cmd_t;
	typedef enum logic {SHAPE_SPHERE = 1'b0, SHAPE_TORUS = 1'b1} shape_t;
	typedef enum logic [2:0] {
		REG_SHAPE = 3'd0,
		REG_COLS  = 3'd1,
		REG_ROWS  = 3'd2,
		REG_MAJOR = 3'd3,
		REG_MINOR = 3'd4
	} reg_idx_t;

	typedef struct packed {
		shape_t             shape;
		logic [SEG_W-1:0]   cols;
		logic [SEG_W-1:0]   rows;
		logic [RAD_W-1:0]   major;
		logic [RAD_W-1:0]   minor;
	} cfg_t;

	typedef struct packed {
		cmd_t             cmd;
		logic [SEG_W-1:0] col;
		logic [SEG_W-1:0] row;
		logic [IDX_W-1:0] idx;
	} q_item_t;

	typedef struct packed {
		cmd_t             kind;
		logic             last;
		logic [IDX_W-1:0] idx;
		logic [TEX_W-1:0] tex_u;
		logic [TEX_W-1:0] tex_v;
	} sb_t;

	function automatic logic [SEG_W-1:0] seg_clamp(input logic [SEG_W-1:0] v);
		logic [SEG_W-1:0] r;
		r = v;
		if (v == '0) r = SEG_W'(1);
		else if (32'(v) > MAX_SEGMENTS) r = SEG_W'(MAX_SEGMENTS);
		return r;
	endfunction

	// add half then floor shift
	function automatic logic signed [WIDE_W-1:0] rnd_shift(
		input logic signed [WIDE_W-1:0] v, input int s);
		logic signed [WIDE_W-1:0] half;
		half = WIDE_W'(1) <<< (s - 1);
		return (v + half) >>> s;
	endfunction

	function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [WIDE_W-1:0] v);
		logic signed [POS_W-1:0] r;
		if (v > WIDE_W'(POS_MAX)) r = POS_W'(POS_MAX);
		else if (v < WIDE_W'(POS_MIN)) r = POS_W'(POS_MIN);
		else r = POS_W'(v);
		return r;
	endfunction

	function automatic logic signed [NORM_W-1:0] sat_norm(input logic signed [WIDE_W-1:0] v);
		logic signed [NORM_W-1:0] r;
		if (v > WIDE_W'(NORM_LIM)) r = NORM_W'(NORM_LIM);
		else if (v < -WIDE_W'(NORM_LIM)) r = -NORM_W'(NORM_LIM);
		else r = NORM_W'(v);
		return r;
	endfunction

endpackage

@@ sv/parametric_sphere_torus_tessellator_core.sv @@
// Tessellator for a unit UV sphere or a torus. A vertex command (one result) can be
// started every cycle while busy is low; a cell command gives six index results on
// consecutive cycles, so the single result port sets the pace for cells and busy rises
// once the four-entry command queue fills behind them. Results pass through the
// 25-stage angle divider and the cordic pipeline and leave in command order; each is
// on the ports for one cycle with result_valid high and cannot be held off.
// depends on tstc_pkg, tstc_front, tstc_queue, tstc_back
module parametric_sphere_torus_tessellator_core #(
	parameter int ANGLE_STEPS = tstc_pkg::ANGLE_STEPS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [tstc_pkg::ADDR_W-1:0]        paddr,
	input  logic [tstc_pkg::DATA_W-1:0]        pwdata,
	output logic [tstc_pkg::DATA_W-1:0]        prdata,
	output logic                               pready,
	input  logic                               start,
	input  logic                               cmd,
	input  logic [tstc_pkg::SEG_W-1:0]         grid_col,
	input  logic [tstc_pkg::SEG_W-1:0]         grid_row,
	output logic                               busy,
	output logic                               result_valid,
	output logic                               result_kind,
	output logic signed [tstc_pkg::POS_W-1:0]  pos_x,
	output logic signed [tstc_pkg::POS_W-1:0]  pos_y,
	output logic signed [tstc_pkg::POS_W-1:0]  pos_z,
	output logic signed [tstc_pkg::NORM_W-1:0] norm_x,
	output logic signed [tstc_pkg::NORM_W-1:0] norm_y,
	output logic signed [tstc_pkg::NORM_W-1:0] norm_z,
	output logic [tstc_pkg::TEX_W-1:0]         tex_u,
	output logic [tstc_pkg::TEX_W-1:0]         tex_v,
	output logic [tstc_pkg::IDX_W-1:0]         vertex_index,
	output logic                               last_of_run
);
	import tstc_pkg::*;

	cfg_t             cfg_q;
	reg_idx_t         reg_sel;
	logic             push, pop, not_empty;
	q_item_t          push_item, head;
	logic [CNT_W-1:0] level;

	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.shape <= SHAPE_SPHERE;
			cfg_q.cols  <= SEG_W'(16);
			cfg_q.rows  <= SEG_W'(16);
			cfg_q.major <= RAD_W'(4096);
			cfg_q.minor <= RAD_W'(2048);
		end else if (psel && penable && pwrite) begin
			unique case (reg_sel)
				REG_SHAPE: cfg_q.shape <= shape_t'(pwdata[0]);
				REG_COLS:  cfg_q.cols  <= pwdata[SEG_W-1:0];
				REG_ROWS:  cfg_q.rows  <= pwdata[SEG_W-1:0];
				REG_MAJOR: cfg_q.major <= pwdata[RAD_W-1:0];
				REG_MINOR: cfg_q.minor <= pwdata[RAD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_SHAPE: prdata = DATA_W'(cfg_q.shape);
			REG_COLS:  prdata = DATA_W'(cfg_q.cols);
			REG_ROWS:  prdata = DATA_W'(cfg_q.rows);
			REG_MAJOR: prdata = DATA_W'(cfg_q.major);
			REG_MINOR: prdata = DATA_W'(cfg_q.minor);
			default:   prdata = '0;
		endcase
	end

	tstc_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd(cmd),
		.grid_col(grid_col), .grid_row(grid_row), .cfg(cfg_q), .q_level(level),
		.busy(busy), .push(push), .push_item(push_item)
	);

	tstc_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_item(push_item), .pop(pop),
		.head(head), .not_empty(not_empty), .level(level)
	);

	tstc_back #(.STEPS(ANGLE_STEPS)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .head(head), .not_empty(not_empty),
		.pop(pop), .result_valid(result_valid), .result_kind(result_kind),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
		.tex_u(tex_u), .tex_v(tex_v), .vertex_index(vertex_index),
		.last_of_run(last_of_run)
	);

endmodule

@@ sv/tstc_front.sv @@
// front end: takes commands, clamps the grid position and forms the base index
// depends on tstc_pkg
module tstc_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     cmd,
	input  logic [tstc_pkg::SEG_W-1:0] grid_col,
	input  logic [tstc_pkg::SEG_W-1:0] grid_row,
	input  tstc_pkg::cfg_t           cfg,
	input  logic [tstc_pkg::CNT_W-1:0] q_level,
	output logic                     busy,
	output logic                     push,
	output tstc_pkg::q_item_t        push_item
);
	import tstc_pkg::*;

	cmd_t               kind;
	logic               accept;
	logic [SEG_W-1:0]   cols, rows, col_lim, row_lim, col_c, row_c;
	logic [SEG_W:0]     width;
	logic [2*SEG_W:0]   row_base;
	logic [IDX_W-1:0]   idx;
	logic               valid_s1;
	q_item_t            item_s1;

	assign kind   = cmd_t'(cmd);
	assign cols   = seg_clamp(cfg.cols);
	assign rows   = seg_clamp(cfg.rows);
	// room must remain for the item already held in the stage register
	assign busy   = (int'(q_level) + int'(valid_s1)) >= QUEUE_DEPTH;
	assign accept = start && !busy;

	always_comb begin
		col_lim = cols;
		row_lim = rows;
		if (kind == CMD_CELL) begin
			col_lim = cols - SEG_W'(1);
			row_lim = rows - SEG_W'(1);
		end
		col_c    = (grid_col > col_lim) ? col_lim : grid_col;
		row_c    = (grid_row > row_lim) ? row_lim : grid_row;
		width    = {1'b0, cols} + (SEG_W+1)'(1);
		row_base = (2*SEG_W+1)'(row_c) * (2*SEG_W+1)'(width);
		idx      = row_base[IDX_W-1:0] + IDX_W'(col_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.cmd <= kind;
			item_s1.col <= col_c;
			item_s1.row <= row_c;
			item_s1.idx <= idx;
		end
	end

	assign push      = valid_s1;
	assign push_item = item_s1;

endmodule

@@ sv/tstc_queue.sv @@
// short queue between front and back ends
// depends on tstc_pkg and the assertion macro header
module tstc_queue (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  tstc_pkg::q_item_t          push_item,
	input  logic                       pop,
	output tstc_pkg::q_item_t          head,
	output logic                       not_empty,
	output logic [tstc_pkg::CNT_W-1:0] level
);
	import tstc_pkg::*;
	`include "parametric_sphere_torus_tessellator_core_defines.svh"

	q_item_t            mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_q, rd_q;
	logic [CNT_W-1:0]   cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			if (pop)  rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			cnt_q <= cnt_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_item;
	end

	assign head      = mem_q[rd_q];
	assign not_empty = cnt_q != '0;
	assign level     = cnt_q;

	`TSTC_ASSERT_NOW(a_push_room, clk, arst_n, push, cnt_q != CNT_W'(QUEUE_DEPTH))
	`TSTC_ASSERT_NOW(a_pop_data, clk, arst_n, pop, cnt_q != '0)
	`TSTC_ASSERT_NOW(a_level_bound, clk, arst_n, 1'b1, cnt_q <= CNT_W'(QUEUE_DEPTH))

endmodule

@@ sv/tstc_div.sv @@
// pipelined restoring divider giving floor(num * 2^24 / den), one quotient bit per stage
// depends on tstc_pkg; expects num no larger than den
module tstc_div (
	input  logic                       clk,
	input  logic [tstc_pkg::SEG_W-1:0] num,
	input  logic [tstc_pkg::SEG_W-1:0] den,
	output logic [tstc_pkg::QUO_W-1:0] quo
);
	import tstc_pkg::*;

	logic [SEG_W-1:0] rem_s [TURN_BITS+1];
	logic [QUO_W-1:0] quo_s [TURN_BITS+1];

	// integer bit: the numerator never exceeds the divisor
	always_ff @(posedge clk) begin
		if (num >= den) begin
			rem_s[0] <= num - den;
			quo_s[0] <= QUO_W'(1);
		end else begin
			rem_s[0] <= num;
			quo_s[0] <= '0;
		end
	end

	for (genvar k = 1; k <= TURN_BITS; k++) begin : g_stage
		logic [SEG_W:0] trial;
		assign trial = {rem_s[k-1], 1'b0};
		always_ff @(posedge clk) begin
			if (trial >= {1'b0, den}) begin
				rem_s[k] <= SEG_W'(trial - {1'b0, den});
				quo_s[k] <= {quo_s[k-1][QUO_W-2:0], 1'b1};
			end else begin
				rem_s[k] <= trial[SEG_W-1:0];
				quo_s[k] <= {quo_s[k-1][QUO_W-2:0], 1'b0};
			end
		end
	end

	assign quo = quo_s[TURN_BITS];

endmodule

@@ sv/tstc_cordic.sv @@
// pipelined rotation cordic: sine and cosine of a 24-bit turn fraction in Q1.14
// depends on tstc_pkg
module tstc_cordic #(
	parameter int STEPS = tstc_pkg::ANGLE_STEPS
) (
	input  logic                                clk,
	input  logic [tstc_pkg::TURN_BITS-1:0]      angle,
	output logic signed [tstc_pkg::NORM_W-1:0]  sn,
	output logic signed [tstc_pkg::NORM_W-1:0]  cs
);
	import tstc_pkg::*;

	typedef enum logic [1:0] {Q_FIRST, Q_SECOND, Q_THIRD, Q_FOURTH} quad_t;

	logic [TURN_BITS-1:0]         shifted;
	logic signed [CORDIC_W-1:0]   x_s [STEPS+1];
	logic signed [CORDIC_W-1:0]   y_s [STEPS+1];
	logic signed [ZW-1:0]         z_s [STEPS+1];
	quad_t                        quad_s [STEPS+1];
	logic signed [NORM_W-1:0]     c_r, s_r;

	// shift by an eighth turn so each quadrant is centred on zero
	assign shifted = angle + TURN_BITS'(EIGHTH);

	always_ff @(posedge clk) begin
		x_s[0]    <= CORDIC_START;
		y_s[0]    <= '0;
		z_s[0]    <= $signed(ZW'(shifted[TURN_BITS-3:0])) - EIGHTH;
		quad_s[0] <= quad_t'(shifted[TURN_BITS-1:TURN_BITS-2]);
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_iter
		localparam logic signed [ZW-1:0] ANG = ZW'(ATAN_TAB[i]);
		always_ff @(posedge clk) begin
			if (!z_s[i][ZW-1]) begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - ANG;
			end else begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + ANG;
			end
			quad_s[i+1] <= quad_s[i];
		end
	end

	assign c_r = sat_norm(rnd_shift(WIDE_W'(x_s[STEPS]), NORM_FRAC));
	assign s_r = sat_norm(rnd_shift(WIDE_W'(y_s[STEPS]), NORM_FRAC));

	always_ff @(posedge clk) begin
		unique case (quad_s[STEPS])
			Q_FIRST: begin
				cs <= c_r;
				sn <= s_r;
			end
			Q_SECOND: begin
				cs <= -s_r;
				sn <= c_r;
			end
			Q_THIRD: begin
				cs <= -c_r;
				sn <= -s_r;
			end
			Q_FOURTH: begin
				cs <= s_r;
				sn <= -c_r;
			end
			default: begin
				cs <= c_r;
				sn <= s_r;
			end
		endcase
	end

endmodule

@@ sv/tstc_back.sv @@
// back end: issues vertex and corner operations, runs dividers, cordics and products
// depends on tstc_pkg, tstc_div, tstc_cordic and the assertion macro header
module tstc_back #(
	parameter int STEPS = tstc_pkg::ANGLE_STEPS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  tstc_pkg::cfg_t                     cfg,
	input  tstc_pkg::q_item_t                  head,
	input  logic                               not_empty,
	output logic                               pop,
	output logic                               result_valid,
	output logic                               result_kind,
	output logic signed [tstc_pkg::POS_W-1:0]  pos_x,
	output logic signed [tstc_pkg::POS_W-1:0]  pos_y,
	output logic signed [tstc_pkg::POS_W-1:0]  pos_z,
	output logic signed [tstc_pkg::NORM_W-1:0] norm_x,
	output logic signed [tstc_pkg::NORM_W-1:0] norm_y,
	output logic signed [tstc_pkg::NORM_W-1:0] norm_z,
	output logic [tstc_pkg::TEX_W-1:0]         tex_u,
	output logic [tstc_pkg::TEX_W-1:0]         tex_v,
	output logic [tstc_pkg::IDX_W-1:0]         vertex_index,
	output logic                               last_of_run
);
	import tstc_pkg::*;
	`include "parametric_sphere_torus_tessellator_core_defines.svh"

	typedef enum logic [2:0] {
		CRN_BL_A, CRN_TL_A, CRN_TR_A, CRN_BL_B, CRN_TR_B, CRN_BR
	} corner_t;

	localparam int LAT_B  = STEPS + 2;
	localparam int LAT    = DIV_LAT + LAT_B;
	localparam int SPH_SH = PROD_FRAC - FRAC_BITS;
	localparam int TOR_SH = TOR_FRAC - FRAC_BITS;

	logic [SEG_W-1:0]   cols, rows;
	logic [IDX_W-1:0]   top, bot, corner_idx;
	logic               is_cell;
	logic               mid_cell;
	corner_t            corner_q;

	logic               vld_s [LAT+1];
	sb_t                sb_s  [LAT+1];
	logic [SEG_W-1:0]   col_s0, row_s0;

	logic [QUO_W-1:0]     quo_c, quo_r;
	logic [TURN_BITS-1:0] ang_v;
	logic signed [NORM_W-1:0] su, cu, sv, cv;

	logic                      vld_s1, vld_s2;
	sb_t                       sb_s1, sb_s2;
	logic signed [CORDIC_W-1:0] x28_s1, z28_s1, cur_s1, sur_s1, cvr_s1;
	logic signed [NORM_W-1:0]  cv_s1;
	logic signed [CORDIC_W-1:0] x28_s2, z28_s2, cur_s2, sur_s2, cvr_s2;
	logic signed [NORM_W-1:0]  cv_s2;
	logic signed [WIDE_W-1:0]  xr_s2, zr_s2;
	logic signed [NORM_W:0]    major_sg, minor_sg;

	logic signed [WIDE_W-1:0]  px_w, py_w, pz_w;
	logic                      valid_q;

	assign cols = seg_clamp(cfg.cols);
	assign rows = seg_clamp(cfg.rows);
	assign major_sg = $signed({2'b00, cfg.major});
	assign minor_sg = $signed({2'b00, cfg.minor});

	// issue side: a cell holds the queue head for its six corners
	assign is_cell = head.cmd == CMD_CELL;
	assign top  = head.idx;
	assign bot  = head.idx + IDX_W'(cols) + IDX_W'(1);
	assign pop  = not_empty && (!is_cell || corner_q == CRN_BR);

	always_comb begin
		unique case (corner_q)
			CRN_BL_A: corner_idx = bot;
			CRN_TL_A: corner_idx = top;
			CRN_TR_A: corner_idx = top + IDX_W'(1);
			CRN_BL_B: corner_idx = bot;
			CRN_TR_B: corner_idx = top + IDX_W'(1);
			CRN_BR:   corner_idx = bot + IDX_W'(1);
			default:  corner_idx = bot;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_q <= CRN_BL_A;
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= not_empty;
			if (not_empty && is_cell) begin
				corner_q <= (corner_q == CRN_BR) ? CRN_BL_A : corner_t'(corner_q + 3'd1);
			end
		end
	end

	always_ff @(posedge clk) begin
		sb_s[0].kind  <= head.cmd;
		sb_s[0].last  <= !is_cell || corner_q == CRN_BR;
		sb_s[0].idx   <= is_cell ? corner_idx : head.idx;
		sb_s[0].tex_u <= '0;
		sb_s[0].tex_v <= '0;
		col_s0        <= head.col;
		row_s0        <= head.row;
	end

	// sideband follows the arithmetic; texture is picked up at the divider exit
	for (genvar k = 0; k < LAT; k++) begin : g_sb
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[k+1] <= 1'b0;
			else         vld_s[k+1] <= vld_s[k];
		end
		if (k == DIV_LAT) begin : g_tex
			always_ff @(posedge clk) begin
				sb_s[k+1].kind  <= sb_s[k].kind;
				sb_s[k+1].last  <= sb_s[k].last;
				sb_s[k+1].idx   <= sb_s[k].idx;
				sb_s[k+1].tex_u <= quo_c[QUO_W-1:TEX_SHIFT];
				sb_s[k+1].tex_v <= quo_r[QUO_W-1:TEX_SHIFT];
			end
		end else begin : g_pass
			always_ff @(posedge clk) begin
				sb_s[k+1] <= sb_s[k];
			end
		end
	end

	tstc_div u_div_col (.clk(clk), .num(col_s0), .den(cols), .quo(quo_c));
	tstc_div u_div_row (.clk(clk), .num(row_s0), .den(rows), .quo(quo_r));

	// sphere uses a half turn for v, the torus a full turn
	assign ang_v = (cfg.shape == SHAPE_SPHERE) ? quo_r[QUO_W-1:1] : quo_r[TURN_BITS-1:0];

	tstc_cordic #(.STEPS(STEPS)) u_cordic_u (
		.clk(clk), .angle(quo_c[TURN_BITS-1:0]), .sn(su), .cs(cu)
	);
	tstc_cordic #(.STEPS(STEPS)) u_cordic_v (
		.clk(clk), .angle(ang_v), .sn(sv), .cs(cv)
	);

	// first products, Q2.28 and radius scaled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			vld_s1 <= vld_s[LAT];
			vld_s2 <= vld_s1;
			valid_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		sb_s1  <= sb_s[LAT];
		x28_s1 <= sv * cu;
		z28_s1 <= sv * su;
		cur_s1 <= cu * major_sg;
		sur_s1 <= su * major_sg;
		cvr_s1 <= cv * minor_sg;
		cv_s1  <= cv;
	end

	always_ff @(posedge clk) begin
		sb_s2  <= sb_s1;
		x28_s2 <= x28_s1;
		z28_s2 <= z28_s1;
		cur_s2 <= cur_s1;
		sur_s2 <= sur_s1;
		cvr_s2 <= cvr_s1;
		cv_s2  <= cv_s1;
		xr_s2  <= x28_s1 * minor_sg;
		zr_s2  <= z28_s1 * minor_sg;
	end

	always_comb begin
		if (cfg.shape == SHAPE_SPHERE) begin
			px_w = rnd_shift(WIDE_W'(x28_s2), SPH_SH);
			py_w = rnd_shift(WIDE_W'(cv_s2) <<< NORM_FRAC, SPH_SH);
			pz_w = rnd_shift(WIDE_W'(z28_s2), SPH_SH);
		end else begin
			px_w = rnd_shift((WIDE_W'(cur_s2) <<< NORM_FRAC) + xr_s2, TOR_SH);
			py_w = rnd_shift(WIDE_W'(cvr_s2) <<< NORM_FRAC, TOR_SH);
			pz_w = rnd_shift((WIDE_W'(sur_s2) <<< NORM_FRAC) + zr_s2, TOR_SH);
		end
	end

	always_ff @(posedge clk) begin
		result_kind  <= sb_s2.kind;
		vertex_index <= sb_s2.idx;
		last_of_run  <= sb_s2.last;
		if (sb_s2.kind == CMD_VERTEX) begin
			pos_x  <= sat_pos(px_w);
			pos_y  <= sat_pos(py_w);
			pos_z  <= sat_pos(pz_w);
			norm_x <= sat_norm(rnd_shift(WIDE_W'(x28_s2), NORM_FRAC));
			norm_y <= sat_norm(WIDE_W'(cv_s2));
			norm_z <= sat_norm(rnd_shift(WIDE_W'(z28_s2), NORM_FRAC));
			tex_u  <= sb_s2.tex_u;
			tex_v  <= sb_s2.tex_v;
		end else begin
			pos_x  <= '0;
			pos_y  <= '0;
			pos_z  <= '0;
			norm_x <= '0;
			norm_y <= '0;
			norm_z <= '0;
			tex_u  <= '0;
			tex_v  <= '0;
		end
	end

	assign result_valid = valid_q;
	assign mid_cell     = vld_s[0] && sb_s[0].kind == CMD_CELL && !sb_s[0].last;

	`TSTC_ASSERT_NOW(a_corner_has_head, clk, arst_n, corner_q != CRN_BL_A, not_empty)
	`TSTC_ASSERT_NEXT(a_cell_continues, clk, arst_n, mid_cell, vld_s[0])
	`TSTC_ASSERT_NOW(a_vertex_is_last, clk, arst_n, valid_q && result_kind == CMD_VERTEX, last_of_run)

endmodule

@@ verif/parametric_sphere_torus_tessellator_core_tb.sv @@
// self-checking testbench for the sphere / torus tessellator core
// predicts every vertex and cell result in fixed point and checks them in order
// depends on tstc_pkg and parametric_sphere_torus_tessellator_core
`timescale 1ns / 100ps

module parametric_sphere_torus_tessellator_core_tb;
	import tstc_pkg::*;

	localparam int LATENCY   = ANGLE_STEPS + 32;
	localparam int STALL_MAX = 4000;

	typedef struct packed {
		logic             kind;
		logic [16:0]      px;
		logic [16:0]      py;
		logic [16:0]      pz;
		logic [15:0]      nx;
		logic [15:0]      ny;
		logic [15:0]      nz;
		logic [15:0]      tu;
		logic [15:0]      tv;
		logic [16:0]      idx;
		logic             last;
	} tess_result_t;

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata, prdata;
	logic pready;
	logic start, cmd, busy, result_valid, result_kind, last_of_run;
	logic [SEG_W-1:0] grid_col, grid_row;
	logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
	logic signed [NORM_W-1:0] norm_x, norm_y, norm_z;
	logic [TEX_W-1:0] tex_u, tex_v;
	logic [IDX_W-1:0] vertex_index;

	// register mirror
	shape_t    m_shape;
	logic [8:0] m_cols, m_rows;
	logic [14:0] m_major, m_minor;

	tess_result_t pending_results[$];
	int mismatches;
	int stall_cycles;
	int idle_pct;

	longint atan_steps[24] = '{2097152, 1238021, 654136, 332050, 166669, 83416,
		41718, 20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81,
		41, 20, 10, 5, 3, 1, 1, 0};

	parametric_sphere_torus_tessellator_core dut (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic longint round_shift(longint v, int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic logic [8:0] clamp_segments(logic [8:0] v);
		if (v == 0) return 9'd1;
		if (v > 256) return 9'd256;
		return v;
	endfunction

	task automatic turn_sin_cos(input logic [23:0] ang, output longint sn, output longint cs);
		logic [23:0] b;
		longint z, x, y, dx, dy, c, s;
		b = ang + 24'h200000;
		z = longint'(b[21:0]) - 2097152;
		x = 163008219;
		y = 0;
		for (int i = 0; i < ANGLE_STEPS && i < 24; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= atan_steps[i];
			end else begin
				x += dx; y -= dy; z += atan_steps[i];
			end
		end
		c = clip(round_shift(x, 14), -16384, 16384);
		s = clip(round_shift(y, 14), -16384, 16384);
		case (b[23:22])
			2'd0: begin cs = c;  sn = s;  end
			2'd1: begin cs = -s; sn = c;  end
			2'd2: begin cs = -c; sn = -s; end
			default: begin cs = s; sn = -c; end
		endcase
	endtask

	// work out what one accepted command yields and queue it
	task automatic predict_tessellation(cmd_t op, longint c, longint r);
		longint cols, rows, w, top, bot, su, cu, sv, cv, px, py, pz, nx, nz, x28, z28;
		longint idx[6];
		tess_result_t e;
		cols = clamp_segments(m_cols);
		rows = clamp_segments(m_rows);
		w = cols + 1;
		if (op == CMD_CELL) begin
			if (c > cols - 1) c = cols - 1;
			if (r > rows - 1) r = rows - 1;
			top = r * w + c;
			bot = (r + 1) * w + c;
			idx = '{bot, top, top + 1, bot, top + 1, bot + 1};
			for (int k = 0; k < 6; k++) begin
				e = '0;
				e.kind = 1'b1;
				e.idx = idx[k][16:0];
				e.last = (k == 5);
				pending_results.insert(pending_results.size(), e);
			end
		end else begin
			if (c > cols) c = cols;
			if (r > rows) r = rows;
			turn_sin_cos(24'(((c << 24) / cols)), su, cu);
			if (m_shape == SHAPE_SPHERE) begin
				turn_sin_cos(24'(((r << 23) / rows)), sv, cv);
				x28 = sv * cu;
				z28 = sv * su;
				px = round_shift(x28, 28 - FRAC_BITS);
				py = round_shift(cv * 16384, 28 - FRAC_BITS);
				pz = round_shift(z28, 28 - FRAC_BITS);
			end else begin
				turn_sin_cos(24'(((r << 24) / rows)), sv, cv);
				x28 = cu * sv;
				z28 = su * sv;
				px = round_shift(cu * m_major * 16384 + x28 * m_minor, 40 - FRAC_BITS);
				py = round_shift(cv * 16384 * m_minor, 40 - FRAC_BITS);
				pz = round_shift(su * m_major * 16384 + z28 * m_minor, 40 - FRAC_BITS);
			end
			nx = round_shift(x28, 14);
			nz = round_shift(z28, 14);
			e.kind = 1'b0;
			e.px = 17'(clip(px, -65536, 65535));
			e.py = 17'(clip(py, -65536, 65535));
			e.pz = 17'(clip(pz, -65536, 65535));
			e.nx = 16'(clip(nx, -16384, 16384));
			e.ny = 16'(clip(cv, -16384, 16384));
			e.nz = 16'(clip(nz, -16384, 16384));
			e.tu = 16'((c * 32768) / cols);
			e.tv = 16'((r * 32768) / rows);
			e.idx = 17'(r * w + c);
			e.last = 1'b1;
			pending_results.insert(pending_results.size(), e);
		end
	endtask

	// result checker and stall watchdog
	always @(posedge clk) begin
		tess_result_t got, exp_r;
		if (result_valid) begin
			got = '{result_kind, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
				tex_u, tex_v, vertex_index, last_of_run};
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", got);
			end else begin
				exp_r = pending_results.pop_front();
				if (got !== exp_r) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, got %p", exp_r, got);
				end
			end
		end
		if (result_valid || (start && !busy) || (psel && penable)) stall_cycles = 0;
		else stall_cycles++;
		if (stall_cycles >= STALL_MAX) begin
			$display("** parametric_sphere_torus_tessellator_core: FAILED **");
			$finish;
		end
	end

	task automatic write_reg(int index, logic [31:0] value);
		paddr <= ADDR_W'(4 * index);
		pwdata <= value;
		pwrite <= 1'b1;
		psel <= 1'b1;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (index)
			REG_SHAPE: m_shape = shape_t'(value[0]);
			REG_COLS:  m_cols = value[8:0];
			REG_ROWS:  m_rows = value[8:0];
			REG_MAJOR: m_major = value[14:0];
			REG_MINOR: m_minor = value[14:0];
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
	endtask

	task automatic set_surface(shape_t s, logic [31:0] c, logic [31:0] r,
		logic [31:0] major, logic [31:0] minor);
		wait_drained();
		write_reg(REG_SHAPE, s);
		write_reg(REG_COLS, c);
		write_reg(REG_ROWS, r);
		write_reg(REG_MAJOR, major);
		write_reg(REG_MINOR, minor);
	endtask

	// one command transfer, with an optional gap afterwards
	task automatic send_command(cmd_t op, logic [8:0] c, logic [8:0] r);
		start <= 1'b1;
		cmd <= op;
		grid_col <= c;
		grid_row <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_tessellation(op, c, r);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	task automatic end_burst();
		start <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_sphere_points();
		idle_pct = 0;
		set_surface(SHAPE_SPHERE, 16, 16, 4096, 2048);
		send_command(CMD_VERTEX, 0, 0);
		send_command(CMD_VERTEX, 16, 16);
		send_command(CMD_VERTEX, 4, 8);
		send_command(CMD_VERTEX, 9'h1FF, 9'h1FF);  // clamped point
		send_command(CMD_VERTEX, 9'h155, 9'h0AA);
		end_burst();
	endtask

	task automatic test_torus_points();
		set_surface(SHAPE_TORUS, 256, 256, 32767, 32767);  // largest radii
		send_command(CMD_VERTEX, 0, 0);
		send_command(CMD_VERTEX, 32, 64);
		send_command(CMD_VERTEX, 160, 200);
		send_command(CMD_VERTEX, 256, 256);
		end_burst();
		set_surface(SHAPE_TORUS, 0, 9'h1FF, 0, 0);  // zero and oversize segment counts
		send_command(CMD_VERTEX, 1, 100);
		send_command(CMD_VERTEX, 0, 256);
		end_burst();
	endtask

	task automatic test_cells();
		set_surface(SHAPE_SPHERE, 256, 256, 4096, 2048);
		send_command(CMD_CELL, 0, 0);
		send_command(CMD_CELL, 255, 255);
		send_command(CMD_CELL, 9'h1FF, 9'h1FF);  // clamped cell
		send_command(CMD_CELL, 9'h0AA, 9'h155);
		send_command(CMD_VERTEX, 256, 256);
		send_command(CMD_CELL, 3, 7);
		end_burst();
		wait_drained();
		write_reg(5, 32'hFFFF_FFFF);  // no register here, must be ignored
		write_reg(7, 32'h0);
		send_command(CMD_CELL, 2, 2);
		end_burst();
	endtask

	task automatic random_burst(int count);
		logic [8:0] c, r;
		cmd_t op;
		for (int n = 0; n < count; n++) begin
			op = cmd_t'($urandom_range(1));
			if ($urandom_range(9) < 7) begin
				c = 9'($urandom_range(clamp_segments(m_cols)));
				r = 9'($urandom_range(clamp_segments(m_rows)));
			end else begin
				c = 9'($urandom);
				r = 9'($urandom);
			end
			send_command(op, c, r);
		end
		end_burst();
	endtask

	task automatic test_random();
		int pct[4] = '{0, 66, 0, 36};
		for (int p = 0; p < 4; p++) begin
			idle_pct = pct[p];
			set_surface(shape_t'($urandom_range(1)), $urandom_range(1, 40),
				$urandom_range(1, 40), $urandom_range(32767), $urandom_range(32767));
			random_burst(40);
		end
		idle_pct = 20;
		set_surface(SHAPE_TORUS, 1, 1, 32767, 0);
		random_burst(10);
		set_surface(SHAPE_SPHERE, 9'h1FF, 256, 0, 32767);
		random_burst(30);
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		start = 1'b0; cmd = 1'b0; grid_col = '0; grid_row = '0;
		mismatches = 0; stall_cycles = 0; idle_pct = 0;
		m_shape = SHAPE_SPHERE; m_cols = 16; m_rows = 16; m_major = 4096; m_minor = 2048;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_sphere_points();
		test_torus_points();
		test_cells();
		test_random();
		wait_drained();
		if (mismatches == 0 && pending_results.size() == 0)
			$display("** parametric_sphere_torus_tessellator_core: PASSED **");
		else
			$display("** parametric_sphere_torus_tessellator_core: FAILED **");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+sv
sv/tstc_pkg.sv
sv/tstc_front.sv
sv/tstc_queue.sv
sv/tstc_div.sv
sv/tstc_cordic.sv
sv/tstc_back.sv
sv/parametric_sphere_torus_tessellator_core.sv
verif/parametric_sphere_torus_tessellator_core_tb.sv
